// ===== rtl/core/hvc_pkg.sv =====
package hvc_pkg;

    // Input sample width (signed Q15.16 at the default of 32)
    localparam int SAMPLE_BITS = 32;

    localparam int MARK_BITS = 32;
    localparam int MIN_SPAN_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int FILL_BITS = FRAC_BITS + 1;
    localparam int SPAN_BITS = MARK_BITS;
    localparam int REM_BITS = SPAN_BITS + 1;
    localparam int WIDE_SPAN_BITS = MARK_BITS + 2;
    localparam int CMP_BITS = ((SAMPLE_BITS > MARK_BITS) ? SAMPLE_BITS : MARK_BITS) + 1;
    localparam int POS_BITS = FILL_BITS + 2;
    localparam int SEG_BITS = POS_BITS - FRAC_BITS;
    localparam int CHAN_BITS = 8;
    localparam int NUM_CELLS = FILL_BITS;

    localparam logic [FILL_BITS-1:0] ONE_Q16 = FILL_BITS'(1) << FRAC_BITS;
    localparam logic [SEG_BITS-1:0] SEGMENTS = SEG_BITS'(5);

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LOW_MARK = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_HIGH_MARK = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_SPAN = 2'd2;

    localparam logic [MARK_BITS-1:0] LOW_MARK_RST = 32'd0;
    localparam logic [MARK_BITS-1:0] HIGH_MARK_RST = 32'd6553600;
    localparam logic [MIN_SPAN_BITS-1:0] MIN_SPAN_RST = 16'd7;

    // Segment end colours as {r, g, b}: black, blue, cyan, green, yellow, red
    localparam logic [5:0][2:0] COLOUR_TAB = {
        3'b100, 3'b110, 3'b010, 3'b011, 3'b001, 3'b000
    };

    localparam int CH_RED = 2;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE = 0;

    // Word handed down the divider row
    typedef struct packed {
        logic                 forced;   // span too narrow, fill is full scale
        logic [REM_BITS-1:0]  rem;      // partial remainder, already shifted
        logic [FILL_BITS-1:0] quo;      // quotient bits so far, MSB first
    } hvc_div_t;

    // One channel: blend of end values a and b, scaled to 0..255, round half up
    function automatic logic [CHAN_BITS-1:0] chan_level(
        input logic                 a,
        input logic                 b,
        input logic [FRAC_BITS-1:0] frac
    );
        logic [FILL_BITS-1:0] v;
        logic [24:0]          t;
        begin
            case ({a, b})
                2'b11:   v = ONE_Q16;
                2'b10:   v = ONE_Q16 - FILL_BITS'(frac);
                2'b01:   v = FILL_BITS'(frac);
                default: v = '0;
            endcase
            t = (25'(v) << 8) - 25'(v) + 25'd32768;
            chan_level = t[23:16];
        end
    endfunction

endpackage

// ===== rtl/core/hvc_sample_if.sv =====
interface hvc_sample_if
    import hvc_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/core/hvc_colour_if.sv =====
interface hvc_colour_if
    import hvc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
    logic [FILL_BITS-1:0] fill_level;

    modport source (output valid, output red, output green, output blue,
                    output fill_level, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input fill_level, output ready);
endinterface

// ===== rtl/core/hvc_cfg_if.sv =====
interface hvc_cfg_if
    import hvc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [MARK_BITS-1:0]     data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/core/hvc_front.sv =====
// Clamp stage: turns the sample into its offset above low_mark, clamped to 0..span.
module hvc_front
    import hvc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [MARK_BITS-1:0]          low_mark,
    input  logic [MARK_BITS-1:0]          high_mark,
    input  logic [SPAN_BITS-1:0]          span,
    input  logic                          forced,
    output logic                          down_valid,
    input  logic                          down_ready,
    output hvc_div_t                      down_data
);
    logic signed [CMP_BITS-1:0] s_ext;
    logic signed [CMP_BITS-1:0] lo_ext;
    logic signed [CMP_BITS-1:0] hi_ext;
    logic signed [CMP_BITS-1:0] diff;
    logic                       below;
    logic                       above;
    logic [SPAN_BITS-1:0]       offset;
    logic                       valid_reg;
    hvc_div_t                   data_reg;
    hvc_div_t                   data_next;

    assign s_ext  = CMP_BITS'(sample);
    assign lo_ext = CMP_BITS'($signed(low_mark));
    assign hi_ext = CMP_BITS'($signed(high_mark));
    assign diff   = s_ext - lo_ext;
    assign below  = s_ext < lo_ext;
    assign above  = s_ext > hi_ext;

    always_comb
    begin
        if (below)
        begin
            offset = '0;
        end
        else if (above)
        begin
            offset = span;
        end
        else
        begin
            offset = diff[SPAN_BITS-1:0];
        end
        data_next.forced = forced;
        data_next.rem    = REM_BITS'(offset);
        data_next.quo    = '0;
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;
endmodule

// ===== rtl/core/hvc_div_cell.sv =====
// One restoring-division step: one quotient bit per cell.
module hvc_div_cell
    import hvc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SPAN_BITS-1:0] span,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  hvc_div_t             up_data,
    output logic                 down_valid,
    input  logic                 down_ready,
    output hvc_div_t             down_data
);
    logic                 take;
    logic [REM_BITS-1:0]  rem_left;
    logic                 valid_reg;
    hvc_div_t             data_reg;
    hvc_div_t             data_next;

    assign take     = up_data.rem >= REM_BITS'(span);
    assign rem_left = take ? (up_data.rem - REM_BITS'(span)) : up_data.rem;

    always_comb
    begin
        data_next.forced = up_data.forced;
        // remainder stays below span, so the shift cannot overflow
        data_next.rem    = {rem_left[REM_BITS-2:0], 1'b0};
        data_next.quo    = {up_data.quo[FILL_BITS-2:0], take};
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;
endmodule

// ===== rtl/core/hvc_colour.sv =====
// Segment lookup and channel interpolation; holds the output register.
module hvc_colour
    import hvc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  hvc_div_t             up_data,
    output logic                 down_valid,
    input  logic                 down_ready,
    output logic [CHAN_BITS-1:0] red,
    output logic [CHAN_BITS-1:0] green,
    output logic [CHAN_BITS-1:0] blue,
    output logic [FILL_BITS-1:0] fill_level
);
    logic [FILL_BITS-1:0] fill;
    logic [POS_BITS-1:0]  pos;
    logic [SEG_BITS-1:0]  seg;
    logic [FRAC_BITS-1:0] frac;
    logic [2:0]           end_a;
    logic [2:0]           end_b;
    logic [CHAN_BITS-1:0] red_next;
    logic [CHAN_BITS-1:0] green_next;
    logic [CHAN_BITS-1:0] blue_next;
    logic                 valid_reg;
    logic [CHAN_BITS-1:0] red_reg;
    logic [CHAN_BITS-1:0] green_reg;
    logic [CHAN_BITS-1:0] blue_reg;
    logic [FILL_BITS-1:0] fill_reg;

    assign fill = up_data.forced ? ONE_Q16 : up_data.quo;
    assign pos  = (POS_BITS'(fill) << 2) + POS_BITS'(fill);
    assign seg  = pos[POS_BITS-1:FRAC_BITS];
    assign frac = pos[FRAC_BITS-1:0];

    always_comb
    begin
        if (seg >= SEGMENTS)
        begin
            // full scale: pure red
            end_a = COLOUR_TAB[SEGMENTS];
            end_b = COLOUR_TAB[SEGMENTS];
        end
        else
        begin
            end_a = COLOUR_TAB[seg];
            end_b = COLOUR_TAB[seg + SEG_BITS'(1)];
        end
        red_next   = chan_level(end_a[CH_RED], end_b[CH_RED], frac);
        green_next = chan_level(end_a[CH_GREEN], end_b[CH_GREEN], frac);
        blue_next  = chan_level(end_a[CH_BLUE], end_b[CH_BLUE], frac);
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            fill_reg  <= fill;
        end
    end

    assign down_valid = valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign fill_level = fill_reg;
endmodule

// ===== rtl/core/heat_value_to_rgb_colour_map.sv =====
// False-colour heat map: one signed Q15.16 sample in, one RGB colour plus
// its Q1.16 fill level out, one result transaction per sample transaction.
// Channels: samples (sink) takes a sample; colours (source) gives red, green,
// blue and fill_level; cfg (sink) writes low_mark (addr 0), high_mark (1)
// and min_span (2). cfg.ready is always high; other addresses are dropped.
// The user must change configuration only while no samples are in flight;
// the block does not enforce this. Pipeline: 19 register stages (one clamp
// stage, 17 divider cells, one colour stage that is also the output
// register). Throughput: one sample per cycle while colours.ready is high;
// the division is spread over the row of 17 cells, one quotient bit each,
// so a new sample enters every cycle.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the
// registers with low_mark = 0, high_mark = 100.0, min_span = 7.
// Stall: when colours.ready is low the result holds in the output register
// and each stage keeps accepting while it has a bubble; samples.ready
// drops only once every stage is full.
module heat_value_to_rgb_colour_map
    import hvc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    hvc_sample_if.sink   samples,
    hvc_colour_if.source colours,
    hvc_cfg_if.sink      cfg
);
    logic [MARK_BITS-1:0]            low_mark_reg;
    logic [MARK_BITS-1:0]            high_mark_reg;
    logic [MIN_SPAN_BITS-1:0]        min_span_reg;
    logic signed [WIDE_SPAN_BITS-1:0] span_wide;
    logic                            forced;

    hvc_div_t lane_data  [NUM_CELLS+1];
    logic     lane_valid [NUM_CELLS+1];
    logic     lane_ready [NUM_CELLS+1];

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_mark_reg  <= LOW_MARK_RST;
            high_mark_reg <= HIGH_MARK_RST;
            min_span_reg  <= MIN_SPAN_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_LOW_MARK:  low_mark_reg  <= cfg.data;
                CFG_HIGH_MARK: high_mark_reg <= cfg.data;
                CFG_MIN_SPAN:  min_span_reg  <= cfg.data[MIN_SPAN_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // Window width; a narrow or inverted window forces full scale. Cells read
    // it directly; only the user keeps it stable while samples are in flight.
    assign span_wide = WIDE_SPAN_BITS'($signed(high_mark_reg))
                     - WIDE_SPAN_BITS'($signed(low_mark_reg));
    assign forced    = span_wide <= $signed(WIDE_SPAN_BITS'(min_span_reg));

    // ------------------------------------------------------------------
    // Clamp stage
    // ------------------------------------------------------------------
    hvc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (samples.valid),
        .up_ready   (samples.ready),
        .sample     (samples.sample),
        .low_mark   (low_mark_reg),
        .high_mark  (high_mark_reg),
        .span       (span_wide[SPAN_BITS-1:0]),
        .forced     (forced),
        .down_valid (lane_valid[0]),
        .down_ready (lane_ready[0]),
        .down_data  (lane_data[0])
    );

    // ------------------------------------------------------------------
    // Divider row: (offset << 16) / span, one quotient bit per cell
    // ------------------------------------------------------------------
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        hvc_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .span       (span_wide[SPAN_BITS-1:0]),
            .up_valid   (lane_valid[i]),
            .up_ready   (lane_ready[i]),
            .up_data    (lane_data[i]),
            .down_valid (lane_valid[i+1]),
            .down_ready (lane_ready[i+1]),
            .down_data  (lane_data[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Colour stage and output register
    // ------------------------------------------------------------------
    hvc_colour u_colour (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (lane_valid[NUM_CELLS]),
        .up_ready   (lane_ready[NUM_CELLS]),
        .up_data    (lane_data[NUM_CELLS]),
        .down_valid (colours.valid),
        .down_ready (colours.ready),
        .red        (colours.red),
        .green      (colours.green),
        .blue       (colours.blue),
        .fill_level (colours.fill_level)
    );
endmodule

// ===== rtl/core/hvc_checker.sv =====
module hvc_checker
    import hvc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [CHAN_BITS-1:0] red,
    input logic [CHAN_BITS-1:0] green,
    input logic [CHAN_BITS-1:0] blue,
    input logic [FILL_BITS-1:0] fill_level
);
    // A stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue) && $stable(fill_level))
        else $error("colour result changed while stalled");

    // Full scale is pure red
    a_full_red: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fill_level == ONE_Q16 |-> red == 8'd255 && green == 8'd0
            && blue == 8'd0)
        else $error("full-scale fill is not pure red");

    // Bottom of the window is black
    a_zero_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fill_level == '0 |-> red == 8'd0 && green == 8'd0
            && blue == 8'd0)
        else $error("zero fill is not black");

    // No segment mixes red with blue
    a_no_magenta: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> red == 8'd0 || blue == 8'd0)
        else $error("red and blue both lit");
endmodule

bind heat_value_to_rgb_colour_map hvc_checker u_hvc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (colours.valid),
    .out_ready  (colours.ready),
    .red        (colours.red),
    .green      (colours.green),
    .blue       (colours.blue),
    .fill_level (colours.fill_level)
);
